// File: rtl/idp_pkg.sv
package idp_pkg;

  localparam int PIXEL_COUNT_BITS_DEF = 22;
  localparam int COMP_W    = 16;
  localparam int DIST_W    = 17;
  localparam int SUM_W     = 56;
  localparam int ROOT_W    = 28;
  localparam int LOG_W     = 21;
  localparam int CFG_IDX_W = 2;

  localparam logic [DIST_W-1:0] DIST_MAX      = 17'h1FFFF;
  localparam logic [18:0]       DB_PER_OCTAVE = 19'd394566;
  localparam logic [15:0]       PSNR_POS_SAT  = 16'h7FFF;
  localparam logic [15:0]       PSNR_NEG_SAT  = 16'h8000;

  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_LIMIT = 2'd2;

  typedef struct packed {
    logic [15:0] ref_red;
    logic [15:0] ref_green;
    logic [15:0] ref_blue;
    logic [15:0] test_red;
    logic [15:0] test_green;
    logic [15:0] test_blue;
    logic        last_pixel;
  } pixel_in_t;

  typedef struct packed {
    logic [16:0]        pixel_difference;
    logic               stats_valid;
    logic [16:0]        max_difference;
    logic [16:0]        rms_error;
    logic signed [15:0] peak_snr;
  } pixel_out_t;

  typedef struct packed {
    logic [15:0] diff_red;
    logic [15:0] diff_green;
    logic [15:0] diff_blue;
    logic [15:0] peak_ref;
    logic        last_pixel;
  } work_item_t;

  typedef struct packed {
    logic [16:0] clip_low;
    logic [16:0] clip_high;
    logic [16:0] clamp_limit;
  } clip_cfg_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_SQUARE,
    BK_DIST_ROOT,
    BK_CLIP,
    BK_ACCUM,
    BK_DIVIDE,
    BK_RMS_ROOT,
    BK_LOG_NORM,
    BK_LOG_MUL,
    BK_LOG_STEP,
    BK_SCALE,
    BK_ROUND,
    BK_EMIT
  } back_state_t;

endpackage

// File: rtl/idp_front.sv
module idp_front
  import idp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  pixel_in_t  in_data,
  output logic       push_valid,
  output work_item_t push_item,
  input  logic       q_full
);

  logic       stage_valid_r;
  logic       stage_valid_nxt;
  work_item_t stage_item_r;
  work_item_t stage_item_nxt;
  logic       accept;

  function automatic logic [15:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
    abs_diff = (a > b) ? a - b : b - a;
  endfunction

  assign in_stall   = stage_valid_r & q_full;
  assign accept     = in_valid & ~in_stall;
  assign push_valid = stage_valid_r;
  assign push_item  = stage_item_r;

  always_comb begin
    stage_item_nxt.diff_red   = abs_diff(in_data.ref_red, in_data.test_red);
    stage_item_nxt.diff_green = abs_diff(in_data.ref_green, in_data.test_green);
    stage_item_nxt.diff_blue  = abs_diff(in_data.ref_blue, in_data.test_blue);
    stage_item_nxt.peak_ref   = in_data.ref_red;
    if (in_data.ref_green > stage_item_nxt.peak_ref) begin
      stage_item_nxt.peak_ref = in_data.ref_green;
    end
    if (in_data.ref_blue > stage_item_nxt.peak_ref) begin
      stage_item_nxt.peak_ref = in_data.ref_blue;
    end
    stage_item_nxt.last_pixel = in_data.last_pixel;
  end

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (accept) begin
      stage_valid_nxt = 1'b1;
    end else if (!q_full) begin
      stage_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_item_r <= stage_item_nxt;
    end
  end

endmodule

// File: rtl/idp_queue.sv
module idp_queue
  import idp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  input  work_item_t push_item,
  output logic       q_full,
  input  logic       q_pop,
  output logic       q_empty,
  output work_item_t q_head
);

  work_item_t entries_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       push;
  logic       pop;

  assign q_full  = (count_r == 2'd2);
  assign q_empty = (count_r == 2'd0);
  assign q_head  = entries_r[rd_ptr_r];
  assign push    = push_valid & ~q_full;
  assign pop     = q_pop & ~q_empty;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: rtl/idp_sqrt.sv
module idp_sqrt
  import idp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SUM_W-1:0]  radicand,
  output logic              busy,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic [SUM_W-1:0]  rad_r;
  logic [SUM_W-1:0]  rad_nxt;
  logic [28:0]       rem_r;
  logic [28:0]       rem_nxt;
  logic [ROOT_W-1:0] root_r;
  logic [ROOT_W-1:0] root_nxt;
  logic [4:0]        cnt_r;
  logic [4:0]        cnt_nxt;
  logic              busy_r;
  logic              busy_nxt;
  logic              done_r;
  logic              done_nxt;
  logic [30:0]       rem_sh;
  logic [30:0]       trial;

  assign busy = busy_r;
  assign done = done_r;
  assign root = root_r;

  assign rem_sh = {rem_r, rad_r[SUM_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};

  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[SUM_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = 29'(rem_sh - trial);
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh[28:0];
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(ROOT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    cnt_r  <= cnt_nxt;
  end

endmodule

// File: rtl/idp_back.sv
module idp_back
  import idp_pkg::*;
#(
  parameter int PIXEL_COUNT_BITS = PIXEL_COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  clip_cfg_t  cfg,
  input  logic       q_empty,
  input  work_item_t q_head,
  output logic       q_pop,
  input  logic       out_stall,
  output logic       out_valid,
  output pixel_out_t out_data
);

  localparam int CNT_W = PIXEL_COUNT_BITS + 1;
  localparam int DIV_W = PIXEL_COUNT_BITS + 2;
  localparam logic [CNT_W-1:0] PIX_MAX = CNT_W'(1) << PIXEL_COUNT_BITS;

  back_state_t       state_r, state_nxt;
  work_item_t        item_r, item_nxt;
  logic [5:0]        step_r, step_nxt;
  logic [33:0]       acc_r, acc_nxt;
  logic [DIST_W-1:0] raw_r, raw_nxt;
  logic [DIST_W-1:0] dist_r, dist_nxt;
  logic [15:0]       peak_comp_r, peak_comp_nxt;
  logic [DIST_W-1:0] peak_diff_r, peak_diff_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SUM_W-1:0]  num_r, num_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  div_r, div_nxt;
  logic [15:0]       pcomp_r, pcomp_nxt;
  logic [DIST_W-1:0] stat_max_r, stat_max_nxt;
  logic [DIST_W-1:0] rms_r, rms_nxt;
  logic [DIST_W-1:0] log_x_r, log_x_nxt;
  logic [30:0]       y_r, y_nxt;
  logic [15:0]       frac_r, frac_nxt;
  logic [4:0]        msb_r, msb_nxt;
  logic [LOG_W-1:0]  log_peak_r, log_peak_nxt;
  logic              log_sel_r, log_sel_nxt;
  logic [LOG_W-1:0]  ldiff_r, ldiff_nxt;
  logic              neg_r, neg_nxt;
  logic [15:0]       psnr_r, psnr_nxt;
  logic [63:0]       prod_r, prod_nxt;
  pixel_out_t        out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic              out_load;
  logic              emit_ok;
  logic              sq_start;
  logic [SUM_W-1:0]  sq_radicand;
  logic              sq_busy;
  logic              sq_done;
  logic [ROOT_W-1:0] sq_root;
  logic [DIST_W-1:0] rms_clamped;
  logic [31:0]       log_t;
  logic [15:0]       frac_step;
  logic [LOG_W-1:0]  log_res;
  logic [DIV_W:0]    div_sh;
  logic [SUM_W:0]    sum_ext;
  logic [40:0]       rnd;
  logic [16:0]       rnd_q;
  logic [16:0]       rnd_neg;
  logic [4:0]        msb_enc;

  idp_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_radicand),
    .busy     (sq_busy),
    .done     (sq_done),
    .root     (sq_root)
  );

  assign out_valid   = out_valid_r;
  assign out_data    = out_r;
  assign emit_ok     = ~out_valid_r | ~out_stall;
  assign prod_nxt    = {32'b0, mul_a} * {32'b0, mul_b};
  assign rms_clamped = (|sq_root[ROOT_W-1:DIST_W]) ? DIST_MAX : sq_root[DIST_W-1:0];
  assign log_t       = prod_r[61:30];
  assign frac_step   = {frac_r[14:0], log_t[31]};
  assign log_res     = {msb_r, frac_step};
  assign div_sh      = {rem_r, num_r[SUM_W-1]};
  assign sum_ext     = {1'b0, sum_r} + {23'b0, prod_r[33:0]};
  assign rnd         = prod_r[40:0] + 41'h800000;
  assign rnd_q       = rnd[40:24];
  assign rnd_neg     = (rnd_q > 17'd32768) ? 17'd32768 : rnd_q;
  assign sq_radicand = (state_r == BK_RMS_ROOT) ? num_r : {22'b0, acc_r};

  always_comb begin
    msb_enc = '0;
    for (int i = 0; i < DIST_W; i++) begin
      if (log_x_r[i]) begin
        msb_enc = 5'(i);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:      if (!q_empty) state_nxt = BK_SQUARE;
      BK_SQUARE:    if (step_r == 6'd3) state_nxt = BK_DIST_ROOT;
      BK_DIST_ROOT: if (sq_done) state_nxt = BK_CLIP;
      BK_CLIP:      state_nxt = BK_ACCUM;
      BK_ACCUM:     state_nxt = item_r.last_pixel ? BK_DIVIDE : BK_EMIT;
      BK_DIVIDE:    if (step_r == 6'(SUM_W - 1)) state_nxt = BK_RMS_ROOT;
      BK_RMS_ROOT: begin
        if (sq_done) begin
          state_nxt = (rms_clamped == '0 || pcomp_r == '0) ? BK_EMIT : BK_LOG_NORM;
        end
      end
      BK_LOG_NORM:  state_nxt = BK_LOG_MUL;
      BK_LOG_MUL:   state_nxt = BK_LOG_STEP;
      BK_LOG_STEP: begin
        if (step_r == 6'd15) begin
          state_nxt = log_sel_r ? BK_SCALE : BK_LOG_NORM;
        end else begin
          state_nxt = BK_LOG_MUL;
        end
      end
      BK_SCALE:     state_nxt = BK_ROUND;
      BK_ROUND:     state_nxt = BK_EMIT;
      BK_EMIT:      if (emit_ok) state_nxt = BK_IDLE;
      default:      state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    item_nxt      = item_r;
    step_nxt      = step_r;
    acc_nxt       = acc_r;
    raw_nxt       = raw_r;
    dist_nxt      = dist_r;
    peak_comp_nxt = peak_comp_r;
    peak_diff_nxt = peak_diff_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    pcomp_nxt     = pcomp_r;
    stat_max_nxt  = stat_max_r;
    rms_nxt       = rms_r;
    log_x_nxt     = log_x_r;
    y_nxt         = y_r;
    frac_nxt      = frac_r;
    msb_nxt       = msb_r;
    log_peak_nxt  = log_peak_r;
    log_sel_nxt   = log_sel_r;
    ldiff_nxt     = ldiff_r;
    neg_nxt       = neg_r;
    psnr_nxt      = psnr_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_load      = 1'b0;
    q_pop         = 1'b0;
    sq_start      = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          item_nxt = q_head;
          step_nxt = '0;
          acc_nxt  = '0;
        end
      end
      BK_SQUARE: begin
        case (step_r)
          6'd0:    mul_a = {16'b0, item_r.diff_red};
          6'd1:    mul_a = {16'b0, item_r.diff_green};
          default: mul_a = {16'b0, item_r.diff_blue};
        endcase
        mul_b = mul_a;
        if (step_r != 6'd0) begin
          acc_nxt = acc_r + prod_r[33:0];
        end
        step_nxt = (step_r == 6'd3) ? 6'd0 : step_r + 6'd1;
      end
      BK_DIST_ROOT: begin
        if (step_r == 6'd0) begin
          sq_start = 1'b1;
          step_nxt = 6'd1;
        end
        if (sq_done) begin
          raw_nxt  = sq_root[DIST_W-1:0];
          step_nxt = '0;
        end
      end
      BK_CLIP: begin
        if (raw_r < cfg.clip_low || raw_r > cfg.clip_high) begin
          dist_nxt = '0;
        end else if (raw_r > cfg.clamp_limit) begin
          dist_nxt = cfg.clamp_limit;
        end else begin
          dist_nxt = raw_r;
        end
        mul_a = {15'b0, dist_nxt};
        mul_b = {15'b0, dist_nxt};
      end
      BK_ACCUM: begin
        sum_nxt       = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
        peak_comp_nxt = (item_r.peak_ref > peak_comp_r) ? item_r.peak_ref : peak_comp_r;
        peak_diff_nxt = (dist_r > peak_diff_r) ? dist_r : peak_diff_r;
        count_nxt     = (count_r == PIX_MAX) ? count_r : count_r + CNT_W'(1);
        if (item_r.last_pixel) begin
          num_nxt       = sum_nxt;
          rem_nxt       = '0;
          div_nxt       = {1'b0, count_nxt} + {count_nxt, 1'b0};
          pcomp_nxt     = peak_comp_nxt;
          stat_max_nxt  = peak_diff_nxt;
          step_nxt      = '0;
          sum_nxt       = '0;
          peak_comp_nxt = '0;
          peak_diff_nxt = '0;
          count_nxt     = '0;
        end
      end
      BK_DIVIDE: begin
        if (div_sh >= {1'b0, div_r}) begin
          rem_nxt = DIV_W'(div_sh - {1'b0, div_r});
          num_nxt = {num_r[SUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = div_sh[DIV_W-1:0];
          num_nxt = {num_r[SUM_W-2:0], 1'b0};
        end
        step_nxt = (step_r == 6'(SUM_W - 1)) ? 6'd0 : step_r + 6'd1;
      end
      BK_RMS_ROOT: begin
        if (step_r == 6'd0) begin
          sq_start = 1'b1;
          step_nxt = 6'd1;
        end
        if (sq_done) begin
          rms_nxt     = rms_clamped;
          step_nxt    = '0;
          log_x_nxt   = {1'b0, pcomp_r};
          log_sel_nxt = 1'b0;
          if (rms_clamped == '0) begin
            psnr_nxt = PSNR_POS_SAT;
          end else if (pcomp_r == '0) begin
            psnr_nxt = PSNR_NEG_SAT;
          end
        end
      end
      BK_LOG_NORM: begin
        msb_nxt  = msb_enc;
        y_nxt    = {14'b0, log_x_r} << (5'd30 - msb_enc);
        frac_nxt = '0;
        step_nxt = '0;
      end
      BK_LOG_MUL: begin
        mul_a = {1'b0, y_r};
        mul_b = {1'b0, y_r};
      end
      BK_LOG_STEP: begin
        y_nxt    = log_t[31] ? log_t[31:1] : log_t[30:0];
        frac_nxt = frac_step;
        step_nxt = step_r + 6'd1;
        if (step_r == 6'd15) begin
          step_nxt = '0;
          if (!log_sel_r) begin
            log_peak_nxt = log_res;
            log_x_nxt    = rms_r;
            log_sel_nxt  = 1'b1;
          end else begin
            neg_nxt   = (log_peak_r < log_res);
            ldiff_nxt = (log_peak_r < log_res) ? log_res - log_peak_r
                                               : log_peak_r - log_res;
          end
        end
      end
      BK_SCALE: begin
        mul_a = {11'b0, ldiff_r};
        mul_b = {13'b0, DB_PER_OCTAVE};
      end
      BK_ROUND: begin
        if (!neg_r) begin
          psnr_nxt = (rnd_q > 17'd32767) ? PSNR_POS_SAT : rnd_q[15:0];
        end else begin
          psnr_nxt = 16'(17'd0 - rnd_neg);
        end
      end
      BK_EMIT: begin
        if (emit_ok) begin
          out_load                 = 1'b1;
          out_valid_nxt            = 1'b1;
          out_nxt.pixel_difference = dist_r;
          out_nxt.stats_valid      = item_r.last_pixel;
          out_nxt.max_difference   = item_r.last_pixel ? stat_max_r : '0;
          out_nxt.rms_error        = item_r.last_pixel ? rms_r : '0;
          out_nxt.peak_snr         = item_r.last_pixel ? psnr_r : '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      peak_comp_r <= '0;
      peak_diff_r <= '0;
      sum_r       <= '0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      peak_comp_r <= peak_comp_nxt;
      peak_diff_r <= peak_diff_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    acc_r      <= acc_nxt;
    raw_r      <= raw_nxt;
    dist_r     <= dist_nxt;
    num_r      <= num_nxt;
    rem_r      <= rem_nxt;
    div_r      <= div_nxt;
    pcomp_r    <= pcomp_nxt;
    stat_max_r <= stat_max_nxt;
    rms_r      <= rms_nxt;
    log_x_r    <= log_x_nxt;
    y_r        <= y_nxt;
    frac_r     <= frac_nxt;
    msb_r      <= msb_nxt;
    log_peak_r <= log_peak_nxt;
    log_sel_r  <= log_sel_nxt;
    ldiff_r    <= ldiff_nxt;
    neg_r      <= neg_nxt;
    psnr_r     <= psnr_nxt;
    prod_r     <= prod_nxt;
    out_r      <= out_nxt;
  end

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == BK_IDLE) && !q_empty)
    else $error("Queue popped outside the idle state.");
  a_root_free: assert property (@(posedge clk) disable iff (!rst_n)
    sq_start |-> !sq_busy)
    else $error("Square root started while busy.");
  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= PIX_MAX)
    else $error("Pixel count exceeded its saturation value.");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || !out_stall))
    else $error("Result register overwritten while stalled.");
`endif

endmodule

// File: rtl/image_difference_psnr_top.sv
// Image difference and PSNR engine, one pixel pair per input transaction.
// Input channel in_valid/in_stall/in_data carries reference and test RGB in
// Q8.8 plus the last-pixel flag; output channel out_valid/out_stall/out_data
// returns one transaction per pixel with the clipped and clamped distance.
// On the last pixel the same transaction carries the maximum difference,
// the RMSE and the PSNR, and the image accumulators are then cleared.
// The configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data is always
// ready and should be written only while the engine is idle.
// A pixel is registered by the front stage and queued in a two-entry queue.
// The back end squares the channel differences of each pixel and runs the
// 28-step square root; the last pixel also needs the 56-step division, a
// second root and two 16-step logarithms, each log step using the one shared
// multiplier. The queue lets the front take a new pixel while the back end
// works, and a result held by out_stall blocks only the next result.
// Synchronous reset restores the register defaults and empties the front
// stage, the queue, the accumulators and the result register.
module image_difference_psnr_top
  import idp_pkg::*;
#(
  parameter int PIXEL_COUNT_BITS = PIXEL_COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pixel_in_t            in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pixel_out_t           out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIST_W-1:0]    cfg_data
);

  clip_cfg_t  cfg_r;
  clip_cfg_t  cfg_nxt;
  logic       push_valid;
  work_item_t push_item;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;
  work_item_t q_head;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CLIP_LOW:    cfg_nxt.clip_low    = cfg_data;
        CFG_CLIP_HIGH:   cfg_nxt.clip_high   = cfg_data;
        CFG_CLAMP_LIMIT: cfg_nxt.clamp_limit = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clip_low    <= '0;
      cfg_r.clip_high   <= DIST_MAX;
      cfg_r.clamp_limit <= DIST_MAX;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  idp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_item  (push_item),
    .q_full     (q_full)
  );

  idp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .q_full     (q_full),
    .q_pop      (q_pop),
    .q_empty    (q_empty),
    .q_head     (q_head)
  );

  idp_back #(
    .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: sim/tb_image_difference_psnr_top.sv
module tb_image_difference_psnr_top
  import idp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int COUNT_BITS = PIXEL_COUNT_BITS_DEF;
  localparam longint unsigned SQ_SUM_MAX = (64'd1 << 56) - 1;
  localparam int IDLE_LIMIT = 20000;
  localparam int LONG_HOLD = 600;
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    pixel_in_t  px;
    bit         typed;
    pixel_out_t res;
  } pixel_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  pixel_in_t            in_data;
  logic                 out_valid;
  logic                 out_stall;
  pixel_out_t           out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIST_W-1:0]    cfg_data;

  clip_cfg_t       clip_model;
  longint unsigned peak_comp_q;
  longint unsigned peak_diff_q;
  longint unsigned sq_sum_q;
  longint unsigned pix_count_q;

  pixel_out_t expected_px[$];
  int         errors;
  int         idle_cycles;
  bit         hold_req;
  int         burst_left;
  pixel_row_t directed[$];

  image_difference_psnr_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned log2_fixed(longint unsigned x);
    longint unsigned y;
    longint unsigned frac;
    int msb;
    msb = 0;
    frac = 0;
    while (msb < 31 && (x >> (msb + 1)) != 0) msb++;
    y = x << (30 - msb);
    for (int i = 0; i < 16; i++) begin
      y = (y * y) >> 30;
      frac <<= 1;
      if (y >= (64'd1 << 31)) begin
        frac |= 1;
        y >>= 1;
      end
    end
    return (longint'(msb) << 16) | frac;
  endfunction

  function automatic logic [15:0] psnr_db(longint unsigned peak, longint unsigned rms);
    longint unsigned lp;
    longint unsigned lr;
    longint unsigned q;
    if (rms == 0) return PSNR_POS_SAT;
    if (peak == 0) return PSNR_NEG_SAT;
    lp = log2_fixed(peak);
    lr = log2_fixed(rms);
    if (lp >= lr) begin
      q = ((lp - lr) * 394566 + (64'd1 << 23)) >> 24;
      return (q > 32767) ? PSNR_POS_SAT : q[15:0];
    end
    q = ((lr - lp) * 394566 + (64'd1 << 23)) >> 24;
    if (q > 32768) q = 32768;
    return 16'(17'h10000 - q[16:0]);
  endfunction

  function automatic pixel_out_t predict_pixel(pixel_in_t p);
    pixel_out_t      r;
    longint unsigned dr, dg, db, distance, mc, sq, rms;
    dr = (p.ref_red > p.test_red) ? p.ref_red - p.test_red : p.test_red - p.ref_red;
    dg = (p.ref_green > p.test_green) ? p.ref_green - p.test_green
                                      : p.test_green - p.ref_green;
    db = (p.ref_blue > p.test_blue) ? p.ref_blue - p.test_blue : p.test_blue - p.ref_blue;
    distance = floor_root(dr * dr + dg * dg + db * db);
    if (distance < clip_model.clip_low || distance > clip_model.clip_high) distance = 0;
    else if (distance > clip_model.clamp_limit) distance = clip_model.clamp_limit;
    distance &= DIST_MAX;
    mc = p.ref_red;
    if (p.ref_green > mc) mc = p.ref_green;
    if (p.ref_blue > mc) mc = p.ref_blue;
    if (mc > peak_comp_q) peak_comp_q = mc;
    if (distance > peak_diff_q) peak_diff_q = distance;
    sq = distance * distance;
    sq_sum_q = (sq_sum_q > SQ_SUM_MAX - sq) ? SQ_SUM_MAX : sq_sum_q + sq;
    if (pix_count_q < (64'd1 << COUNT_BITS)) pix_count_q++;
    r = '0;
    r.pixel_difference = distance[16:0];
    if (p.last_pixel) begin
      rms = floor_root(sq_sum_q / (3 * pix_count_q));
      if (rms > DIST_MAX) rms = DIST_MAX;
      r.stats_valid = 1'b1;
      r.max_difference = peak_diff_q[16:0];
      r.rms_error = rms[16:0];
      r.peak_snr = psnr_db(peak_comp_q, rms);
      peak_comp_q = 0;
      peak_diff_q = 0;
      sq_sum_q = 0;
      pix_count_q = 0;
    end
    return r;
  endfunction

  task automatic send_pixel(pixel_in_t p, bit typed, pixel_out_t res);
    pixel_out_t pred;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (!(in_valid && !in_stall));
    pred = predict_pixel(p);
    expected_px.push_back(typed ? res : pred);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_px.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_put(logic [CFG_IDX_W-1:0] idx, logic [DIST_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      CFG_CLIP_LOW:    clip_model.clip_low = val;
      CFG_CLIP_HIGH:   clip_model.clip_high = val;
      CFG_CLAMP_LIMIT: clip_model.clamp_limit = val;
      default: ;
    endcase
  endtask

  task automatic set_window(logic [16:0] lo, logic [16:0] hi, logic [16:0] lim);
    wait_drained();
    cfg_put(CFG_CLIP_LOW, lo);
    cfg_put(CFG_UNUSED, 17'($urandom));
    cfg_put(CFG_CLIP_HIGH, hi);
    cfg_put(CFG_CLAMP_LIMIT, lim);
    cfg_valid <= 1'b0;
  endtask

  function automatic pixel_in_t random_pixel(int frame_left);
    pixel_in_t p;
    logic [15:0] spread;
    p.ref_red = 16'($urandom);
    p.ref_green = 16'($urandom);
    p.ref_blue = 16'($urandom);
    case ($urandom_range(0, 5))
      0, 1: begin
        p.test_red = 16'($urandom);
        p.test_green = 16'($urandom);
        p.test_blue = 16'($urandom);
      end
      2: begin
        p.test_red = p.ref_red;
        p.test_green = p.ref_green;
        p.test_blue = p.ref_blue;
      end
      3: begin
        p.ref_red = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
        p.test_red = ~p.ref_red;
        p.test_green = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
        p.test_blue = 16'($urandom);
      end
      default: begin
        spread = 16'($urandom_range(0, 2048));
        p.test_red = p.ref_red + 16'($urandom_range(0, spread));
        p.test_green = p.ref_green - 16'($urandom_range(0, spread));
        p.test_blue = p.ref_blue ^ 16'($urandom_range(0, spread));
      end
    endcase
    if ($urandom_range(0, 15) == 0) begin
      p.ref_red = 16'h0;
      p.ref_green = 16'h0;
      p.ref_blue = 16'h0;
    end
    p.last_pixel = (frame_left == 1);
    return p;
  endfunction

  task automatic run_random(int n, bit with_hold);
    int frame_left;
    frame_left = 0;
    for (int i = 0; i < n || frame_left != 0; i++) begin
      if (frame_left == 0)
        frame_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                  : $urandom_range(1, 8);
      if (with_hold && i == n / 2) hold_req = 1'b1;
      send_pixel(random_pixel(frame_left), 1'b0, '0);
      frame_left--;
    end
  endtask

  function automatic pixel_row_t row(logic [15:0] rr, logic [15:0] rg, logic [15:0] rb,
                                     logic [15:0] tr, logic [15:0] tg, logic [15:0] tb,
                                     logic last);
    pixel_row_t r;
    r.px = '{rr, rg, rb, tr, tg, tb, last};
    r.typed = 1'b0;
    r.res = '0;
    return r;
  endfunction

  initial begin
    int mode;
    mode = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (expected_px.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data);
          errors++;
        end else begin
          pixel_out_t e;
          e = expected_px.pop_front();
          if (out_data.pixel_difference !== e.pixel_difference) begin
            $display("%0t: pixel_difference expected %0d actual %0d", $time,
                     e.pixel_difference, out_data.pixel_difference);
            errors++;
          end
          if (out_data.stats_valid !== e.stats_valid) begin
            $display("%0t: stats_valid expected %0d actual %0d", $time,
                     e.stats_valid, out_data.stats_valid);
            errors++;
          end
          if (out_data.max_difference !== e.max_difference) begin
            $display("%0t: max_difference expected %0d actual %0d", $time,
                     e.max_difference, out_data.max_difference);
            errors++;
          end
          if (out_data.rms_error !== e.rms_error) begin
            $display("%0t: rms_error expected %0d actual %0d", $time,
                     e.rms_error, out_data.rms_error);
            errors++;
          end
          if (out_data.peak_snr !== e.peak_snr) begin
            $display("%0t: peak_snr expected %0d actual %0d", $time,
                     e.peak_snr, out_data.peak_snr);
            errors++;
          end
        end
      end
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        if ($urandom_range(0, 199) == 0) mode = $urandom_range(0, 2);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[image_difference_psnr_top] ERROR");
      $finish;
    end
  end

  initial begin
    pixel_row_t r;
    errors = 0;
    idle_cycles = 0;
    hold_req = 1'b0;
    burst_left = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_CLIP_LOW;
    cfg_data = '0;
    clip_model = '{17'h0, DIST_MAX, DIST_MAX};
    peak_comp_q = 0;
    peak_diff_q = 0;
    sq_sum_q = 0;
    pix_count_q = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A black pixel alone gives a zero RMSE, so the PSNR saturates high.
    r = row(0, 0, 0, 0, 0, 0, 1);
    r.typed = 1'b1;
    r.res = '{17'd0, 1'b1, 17'd0, 17'd0, PSNR_POS_SAT};
    directed.push_back(r);
    // A black reference with a nonzero error saturates the PSNR low.
    r = row(0, 0, 0, 16'h0100, 0, 0, 1);
    r.typed = 1'b1;
    r.res = '{17'd256, 1'b1, 17'd256, 17'd147, PSNR_NEG_SAT};
    directed.push_back(r);
    directed.push_back(row(16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0, 1));
    directed.push_back(row(0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0));
    directed.push_back(row(16'hFFFF, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 1));
    directed.push_back(row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE, 1));
    directed.push_back(row(16'h8000, 16'h4000, 16'h2000, 16'h8001, 16'h4001, 16'h2001, 0));
    directed.push_back(row(16'h0001, 16'h0002, 16'h0003, 16'h0000, 16'h0000, 16'h0000, 0));
    directed.push_back(row(16'h1234, 16'hABCD, 16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0, 1));
    directed.push_back(row(16'h0100, 16'h0100, 16'h0100, 16'h0100, 16'h0100, 16'h0100, 1));
    directed.push_back(row(16'h00FF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1));
    foreach (directed[i]) send_pixel(directed[i].px, directed[i].typed, directed[i].res);

    run_random(300, 1'b0);
    set_window(17'h02000, 17'h01000, DIST_MAX);
    directed[2].typed = 1'b0;
    send_pixel(directed[2].px, 1'b0, '0);
    run_random(100, 1'b0);
    set_window(17'h0, DIST_MAX, 17'h00100);
    run_random(250, 1'b1);
    set_window(17'h00080, 17'h08000, 17'h04000);
    run_random(300, 1'b0);
    set_window(DIST_MAX, DIST_MAX, 17'h0);
    send_pixel(directed[2].px, 1'b0, '0);
    run_random(150, 1'b0);
    set_window(17'h0, DIST_MAX, DIST_MAX);
    run_random(400, 1'b0);

    in_valid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[image_difference_psnr_top] OK");
    end else begin
      $display("[image_difference_psnr_top] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/idp_pkg.sv
rtl/idp_front.sv
rtl/idp_queue.sv
rtl/idp_sqrt.sv
rtl/idp_back.sv
rtl/image_difference_psnr_top.sv
sim/tb_image_difference_psnr_top.sv
